### rtl/ufsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufsf_pkg;

	localparam int NODE_COUNT = 16;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int FIELD_W    = 4;
	localparam int TREE_W     = 4;
	localparam int COVER_W    = 5;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [TREE_W-1:0]  TREE_MAX  = {TREE_W{1'b1}};
	localparam logic [COVER_W-1:0] COVER_MAX = {COVER_W{1'b1}};

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] node_a;
		logic [FIELD_W-1:0] node_b;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [TREE_W-1:0]  tree_edge_count;
		logic [COVER_W-1:0] covered_node_count;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_EDGE,
		CMD_REJECT,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [FIELD_W-1:0] node_a;
		logic [FIELD_W-1:0] node_b;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} cmd_hs_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND_A,
		S_FIND_B,
		S_COMMIT
	} state_t;

endpackage

`default_nettype wire

### rtl/ufsf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire ufsf_pkg::in_item_t item,
	output ufsf_pkg::cmd_t       cmd,
	input  wire logic            cmd_ready,
	output logic                 cmd_valid
);
	import ufsf_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             fifo_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             cls;
	logic             in_range;
	logic             do_push;
	logic             do_pop;

	assign in_range = (32'(item.node_a) < NODE_COUNT) && (32'(item.node_b) < NODE_COUNT);

	always_comb begin
		cls.node_a = item.node_a;
		cls.node_b = item.node_b;
		priority if (item.op) begin
			cls.kind = CMD_CLEAR;
		end else if (!in_range || item.node_a == item.node_b) begin
			cls.kind = CMD_REJECT;
		end else begin
			cls.kind = CMD_EDGE;
		end
	end

	assign full      = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (32'(wr_q) == CMDQ_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (32'(rd_q) == CMDQ_DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/ufsf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ufsf_pkg::cmd_t   cmd,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	output ufsf_pkg::out_item_t   result,
	output logic                  empty,
	input  wire logic             pop
);
	import ufsf_pkg::*;

	logic [NODE_W-1:0]  parent_q [NODE_COUNT];
	logic [NODE_COUNT-1:0] touched_q;
	logic [TREE_W-1:0]  tree_q;
	logic [COVER_W-1:0] cov_q;
	out_item_t          result_q;
	logic               out_valid_q;

	state_t             state_q, state_d;
	logic [NODE_W-1:0]  cur_q, cur_d;
	logic [NODE_W-1:0]  root_a_q, root_a_d;
	logic [NODE_W-1:0]  root_b_q, root_b_d;
	cmd_kind_t          kind_q;
	logic [NODE_W-1:0]  a_q;
	logic [NODE_W-1:0]  b_q;

	logic [NODE_W-1:0]  up;
	logic               slot_free;
	logic               commit;
	logic               link;
	logic [TREE_W-1:0]  tree_n;
	logic [COVER_W:0]   cov_sum;
	logic [COVER_W-1:0] cov_n;

	assign up        = parent_q[cur_q];
	assign slot_free = !out_valid_q || pop;
	assign link      = (kind_q == CMD_EDGE) && (root_a_q != root_b_q);
	assign tree_n    = (tree_q == TREE_MAX) ? tree_q : tree_q + 1'b1;
	assign cov_sum   = {1'b0, cov_q} + (COVER_W + 1)'(!touched_q[a_q])
		+ (COVER_W + 1)'(!touched_q[b_q]);
	assign cov_n     = (cov_sum > {1'b0, COVER_MAX}) ? COVER_MAX : cov_sum[COVER_W-1:0];

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		root_a_d  = root_a_q;
		root_b_d  = root_b_q;
		cmd_ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cur_d   = NODE_W'(cmd.node_a);
					state_d = (cmd.kind == CMD_EDGE) ? S_FIND_A : S_COMMIT;
				end
			end
			S_FIND_A: begin
				if (up == cur_q) begin
					root_a_d = cur_q;
					cur_d    = b_q;
					state_d  = S_FIND_B;
				end else begin
					cur_d = up;
				end
			end
			S_FIND_B: begin
				if (up == cur_q) begin
					root_b_d = cur_q;
					state_d  = S_COMMIT;
				end else begin
					cur_d = up;
				end
			end
			S_COMMIT: begin
				if (slot_free) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		root_a_q <= root_a_d;
		root_b_q <= root_b_d;
		if (cmd_ready && cmd_valid) begin
			kind_q <= cmd.kind;
			a_q    <= NODE_W'(cmd.node_a);
			b_q    <= NODE_W'(cmd.node_b);
		end
		if (commit) begin
			priority if (kind_q == CMD_CLEAR) begin
				result_q <= '{accepted: 1'b0, tree_edge_count: '0, covered_node_count: '0};
			end else if (link) begin
				result_q <= '{accepted: 1'b1, tree_edge_count: tree_n, covered_node_count: cov_n};
			end else begin
				result_q <= '{accepted: 1'b0, tree_edge_count: tree_q, covered_node_count: cov_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				parent_q[i] <= NODE_W'(i);
			end
			touched_q   <= '0;
			tree_q      <= '0;
			cov_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				priority if (kind_q == CMD_CLEAR) begin
					for (int i = 0; i < NODE_COUNT; i++) begin
						parent_q[i] <= NODE_W'(i);
					end
					touched_q <= '0;
					tree_q    <= '0;
					cov_q     <= '0;
				end else if (link) begin
					parent_q[root_a_q] <= root_b_q;
					touched_q          <= touched_q | (NODE_COUNT'(1) << a_q)
						| (NODE_COUNT'(1) << b_q);
					tree_q             <= tree_n;
					cov_q              <= cov_n;
				end else begin
					tree_q <= tree_q;
				end
			end
		end
	end

	assign result = result_q;
	assign empty  = !out_valid_q;

endmodule

`default_nettype wire

### rtl/union_find_spanning_forest_filter.sv
// Steps: a clear or rejected item goes from accept straight to commit; an edge
// walks from a, then from b, up to its root, one parent-table read per hop, then commits.
// One item at a time in the find sequencer, which waits in commit for a free result slot;
// a 2-entry command queue takes new items while the sequencer walks.
// Reset (arst_n low, asynchronous): every node its own root, marks and counts zero,
// both queues empty.
`timescale 1ns / 1ps
`default_nettype none

module union_find_spanning_forest_filter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire ufsf_pkg::in_item_t  item,
	output logic                     empty,
	input  wire logic                pop,
	output ufsf_pkg::out_item_t      result
);
	import ufsf_pkg::*;

	cmd_t    cmd;
	cmd_hs_t hs;

	ufsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd       (cmd),
		.cmd_ready (hs.ready),
		.cmd_valid (hs.valid)
	);

	ufsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (hs.valid),
		.cmd_ready (hs.ready),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

### rtl/ufsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsf_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic                full,
	input  wire ufsf_pkg::in_item_t  item,
	input  wire logic                empty,
	input  wire logic                pop,
	input  wire ufsf_pkg::out_item_t result
);
	import ufsf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_tree_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.accepted |-> result.tree_edge_count != '0)
		else $error("accepted edge with zero tree count");

	a_cover_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.accepted |-> result.covered_node_count >= COVER_W'(2))
		else $error("accepted edge covers fewer than two nodes");

	a_cover_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> 32'(result.covered_node_count) <= NODE_COUNT)
		else $error("covered count above node count");

endmodule

bind union_find_spanning_forest_filter ufsf_checker u_ufsf_checker (.*);

`default_nettype wire
